>>> rtl/utf8sd_pkg.sv
// Package with the types, constants and decode functions of the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned BufN  = 4;
  localparam int unsigned CntW  = 3;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0] MinCp2      = 21'h000080;
  localparam logic [CpW-1:0] MinCp3      = 21'h000800;
  localparam logic [CpW-1:0] MinCp4      = 21'h010000;

  localparam logic [CntW-1:0] Len2 = 3'd2;
  localparam logic [CntW-1:0] Len3 = 3'd3;
  localparam logic [CntW-1:0] Len4 = 3'd4;

  typedef logic [BufN-1:0][ByteW-1:0] buf_t;

  typedef struct packed {
    logic            emit;
    logic [CpW-1:0]  cp;
    logic            err;
    logic [CntW-1:0] consume;
  } step_t;

  // One pass of the decode loop on the bytes at the head of the buffer.
  function automatic step_t step_fn(input buf_t b, input logic [CntW-1:0] n,
                                    input logic eos);
    step_t           s;
    logic [CntW-1:0] len;
    logic [CntW-1:0] lim;
    logic            bad;
    logic            range_bad;
    logic [CpW-1:0]  cp;
    int              i;
    s = '0;
    len = '0;
    if (b[0][7:5] == 3'b110) begin
      len = Len2;
    end else if (b[0][7:4] == 4'b1110) begin
      len = Len3;
    end else if (b[0][7:3] == 5'b11110) begin
      len = Len4;
    end
    lim = (n < len) ? n : len;
    bad = 1'b0;
    for (i = 1; i < BufN; i++) begin
      if ((CntW'(i) < lim) && (b[i][7:6] != 2'b10)) begin
        bad = 1'b1;
      end
    end
    case (len)
      Len2: cp = {10'd0, b[0][4:0], b[1][5:0]};
      Len3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      Len4: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      default: cp = '0;
    endcase
    case (len)
      Len2: range_bad = (cp < MinCp2);
      Len3: range_bad = (cp < MinCp3);
      Len4: range_bad = (cp < MinCp4) || (cp > CpMax);
      default: range_bad = 1'b1;
    endcase
    if (n != '0) begin
      if (!b[0][7]) begin
        s.emit = 1'b1;
        s.cp = {13'd0, b[0]};
        s.consume = 3'd1;
      end else if ((len == '0) || bad || range_bad && (n >= len)) begin
        s.emit = 1'b1;
        s.cp = Replacement;
        s.err = 1'b1;
        s.consume = 3'd1;
      end else if (n < len) begin
        if (eos) begin
          s.emit = 1'b1;
          s.cp = Replacement;
          s.err = 1'b1;
          s.consume = 3'd1;
        end
      end else begin
        s.emit = 1'b1;
        s.cp = cp;
        s.consume = len;
      end
    end
    return s;
  endfunction

  // Drops the consumed bytes from the head of the buffer.
  function automatic buf_t shift_fn(input buf_t b, input logic [CntW-1:0] c);
    buf_t            r;
    logic [CntW-1:0] idx;
    int              j;
    r = '0;
    for (j = 0; j < BufN; j++) begin
      idx = CntW'(j) + c;
      if (idx < CntW'(BufN)) begin
        r[j] = b[idx[1:0]];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/utf8sd_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
interface utf8sd_byte_if import utf8sd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface utf8sd_cp_if import utf8sd_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           is_error;
  logic           last_of_run;

  modport source (output valid, output code_point, output is_error, output last_of_run,
                  input ready);
  modport sink (input valid, input code_point, input is_error, input last_of_run,
                output ready);
endinterface

>>> rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: one code point per beat, U+FFFD for malformed input.
// Bytes are taken into a byte buffer; each result is registered at the output.
// Throughput: one byte and one result per cycle while output is ready; after an error
// buffered bytes replay at one result per cycle and input waits while they drain.
// Reset: rst_ni clears the byte buffer, its count, the end flag and the output valid.
module utf8_stream_decoder import utf8sd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8sd_byte_if.sink  bytes_i,
  utf8sd_cp_if.source  cps_o
);

  buf_t            buf_q, buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            eos_q, eos_d;
  logic            out_valid_q, out_valid_d;
  logic [CpW-1:0]  out_cp_q;
  logic            out_err_q;
  logic            out_last_q;

  step_t           cur;
  step_t           nxt;
  buf_t            rest_buf;
  logic [CntW-1:0] rest_cnt;
  buf_t            base_buf;
  logic [CntW-1:0] base_cnt;
  logic            busy;
  logic            last;
  logic            fire;
  logic            accept;

  assign cur      = step_fn(buf_q, cnt_q, eos_q);
  assign rest_buf = shift_fn(buf_q, cur.consume);
  assign rest_cnt = cnt_q - cur.consume;
  assign nxt      = step_fn(rest_buf, rest_cnt, eos_q);
  assign busy     = cur.emit;
  assign last     = !nxt.emit;
  assign fire     = busy && (!out_valid_q || cps_o.ready);

  assign bytes_i.ready = !busy || (fire && last);
  assign accept        = bytes_i.valid && bytes_i.ready;

  always_comb begin
    base_buf = fire ? rest_buf : buf_q;
    base_cnt = fire ? rest_cnt : cnt_q;
    buf_d = base_buf;
    cnt_d = base_cnt;
    eos_d = eos_q;
    if (accept) begin
      buf_d[base_cnt[1:0]] = bytes_i.in_byte;
      cnt_d = base_cnt + 3'd1;
      eos_d = bytes_i.end_of_stream;
    end
    out_valid_d = fire || (out_valid_q && !cps_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      eos_q       <= eos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_cp_q   <= cur.cp;
      out_err_q  <= cur.err;
      out_last_q <= last;
    end
  end

  assign cps_o.valid       = out_valid_q;
  assign cps_o.code_point  = out_cp_q;
  assign cps_o.is_error    = out_err_q;
  assign cps_o.last_of_run = out_last_q;

  // An idle buffer holds only the open prefix of one sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy |-> cnt_q <= 3'd3)
    else $error("idle buffer holds more than three bytes");

  // After the end of the stream the buffer always drains completely.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (!busy && eos_q) |-> cnt_q == '0)
    else $error("bytes left pending after end of stream");

  // A result not marked last is always followed by another result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (fire && !last) |=> busy)
    else $error("run ended without a last result");

endmodule

>>> tb/utf8_stream_decoder_tb.sv
// Self-checking testbench for the UTF-8 stream decoder with directed and random byte streams.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb import utf8sd_pkg::*; ();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DirectedN  = 25;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
    logic           last;
  } cp_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             eos;
    logic             typed;
    logic [CpW-1:0]   cp;
    logic             err;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  utf8sd_byte_if byt ();
  utf8sd_cp_if   cps ();

  utf8_stream_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bytes_i (byt),
    .cps_o   (cps)
  );

  logic [ByteW-1:0] held_bytes[$];
  cp_beat_t         step_cps[$];
  cp_beat_t         cps_due[$];
  logic [ByteW-1:0] unit_bytes[$];
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      mismatches;
  int unsigned      cycles;

  stim_row_t script [DirectedN] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
    '{8'h80, 1'b0, 1'b1, Replacement, 1'b1},
    '{8'hFF, 1'b0, 1'b1, Replacement, 1'b1},
    '{8'hF8, 1'b0, 1'b1, Replacement, 1'b1},
    '{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hED, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h98, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hC0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h82, 1'b1, 1'b0, 21'h0, 1'b0},
    '{8'hF7, 1'b1, 1'b1, Replacement, 1'b1}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void note_cp(input logic [CpW-1:0] cp, input logic err);
    cp_beat_t beat;
    beat.cp   = cp;
    beat.err  = err;
    beat.last = 1'b0;
    step_cps.push_back(beat);
  endfunction

  // Decodes the held bytes plus one new byte; results go to step_cps.
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic eos);
    logic [ByteW-1:0] seq[$];
    logic [ByteW-1:0] b0;
    int unsigned      pos;
    int unsigned      len;
    int unsigned      avail;
    int unsigned      lim;
    int unsigned      i;
    int unsigned      cp;
    int unsigned      min_cp;
    bit               bad;
    bit               stall;
    seq = held_bytes;
    seq.push_back(b);
    step_cps.delete();
    pos   = 0;
    stall = 1'b0;
    while ((pos < seq.size()) && !stall) begin
      b0  = seq[pos];
      len = 0;
      if (!b0[7]) begin
        note_cp(CpW'(b0), 1'b0);
        pos++;
      end else begin
        if (b0[7:5] == 3'b110) begin
          len = 2;
          cp = b0[4:0];
          min_cp = MinCp2;
        end else if (b0[7:4] == 4'b1110) begin
          len = 3;
          cp = b0[3:0];
          min_cp = MinCp3;
        end else if (b0[7:3] == 5'b11110) begin
          len = 4;
          cp = b0[2:0];
          min_cp = MinCp4;
        end
        if (len == 0) begin
          note_cp(Replacement, 1'b1);
          pos++;
        end else begin
          avail = seq.size() - pos;
          lim   = (avail < len) ? avail : len;
          bad   = 1'b0;
          for (i = 1; i < lim; i++) begin
            if (!bad) begin
              if (seq[pos+i][7:6] != 2'b10) begin
                bad = 1'b1;
              end else begin
                cp = (cp << 6) | seq[pos+i][5:0];
              end
            end
          end
          if (bad) begin
            note_cp(Replacement, 1'b1);
            pos++;
          end else if (avail < len) begin
            if (eos) begin
              note_cp(Replacement, 1'b1);
              pos++;
            end else begin
              stall = 1'b1;
            end
          end else if ((cp < min_cp) || (cp > CpMax)) begin
            note_cp(Replacement, 1'b1);
            pos++;
          end else begin
            note_cp(CpW'(cp), 1'b0);
            pos += len;
          end
        end
      end
    end
    held_bytes.delete();
    for (i = pos; i < seq.size(); i++) begin
      held_bytes.push_back(seq[i]);
    end
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic eos, input logic typed,
                           input logic [CpW-1:0] tcp, input logic terr);
    cp_beat_t beat;
    int       i;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byt.valid <= 1'b0;
      @(negedge clk_i);
    end
    byt.valid         <= 1'b1;
    byt.in_byte       <= b;
    byt.end_of_stream <= eos;
    @(posedge clk_i);
    while (!byt.ready) @(posedge clk_i);
    decode_byte(b, eos);
    if (typed) begin
      beat.cp   = tcp;
      beat.err  = terr;
      beat.last = 1'b1;
      cps_due.push_back(beat);
    end else begin
      for (i = 0; i < step_cps.size(); i++) begin
        beat      = step_cps[i];
        beat.last = (i == step_cps.size() - 1);
        cps_due.push_back(beat);
      end
    end
  endtask

  function automatic void encode_cp(input int unsigned cp, input int unsigned len);
    unit_bytes.delete();
    case (len)
      2: begin
        unit_bytes.push_back({3'b110, cp[10:6]});
      end
      3: begin
        unit_bytes.push_back({4'b1110, cp[15:12]});
        unit_bytes.push_back({2'b10, cp[11:6]});
      end
      default: begin
        unit_bytes.push_back({5'b11110, cp[20:18]});
        unit_bytes.push_back({2'b10, cp[17:12]});
        unit_bytes.push_back({2'b10, cp[11:6]});
      end
    endcase
    unit_bytes.push_back({2'b10, cp[5:0]});
  endfunction

  // Mostly well-formed sequences, with overlong, out-of-range, cut and noise bytes mixed in.
  task automatic send_random(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned cp;
    int unsigned i;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      unit_bytes.delete();
      if (kind < 30) begin
        unit_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 70) begin
        case (len)
          2: cp = $urandom_range(32'h80, 32'h7FF);
          3: cp = $urandom_range(32'h800, 32'hFFFF);
          default: cp = $urandom_range(32'h10000, 32'h10FFFF);
        endcase
        encode_cp(cp, len);
      end else if (kind < 80) begin
        case (len)
          2: cp = $urandom_range(0, 32'h7F);
          3: cp = $urandom_range(0, 32'h7FF);
          default: cp = $urandom_range(0, 1) ? $urandom_range(32'h110000, 32'h1FFFFF)
                                             : $urandom_range(0, 32'hFFFF);
        endcase
        encode_cp(cp, len);
      end else if (kind < 90) begin
        encode_cp($urandom_range(32'h800, 32'h10FFFF), 4);
        cut = $urandom_range(1, 3);
        unit_bytes[cut] = 8'($urandom_range(0, 255));
        while (unit_bytes.size() > cut + 1) unit_bytes.pop_back();
      end else begin
        unit_bytes.push_back(8'($urandom_range(0, 255)));
      end
      for (i = 0; i < unit_bytes.size(); i++) begin
        send_byte(unit_bytes[i], ($urandom_range(0, 29) == 0), 1'b0, '0, 1'b0);
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    cps.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cp_beat_t want;
    if (rst_ni && cps.valid && cps.ready) begin
      if (cps_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: cp %h err %b last %b", $time, cps.code_point,
                 cps.is_error, cps.last_of_run);
      end else begin
        want = cps_due.pop_front();
        if ((cps.code_point !== want.cp) || (cps.is_error !== want.err) ||
            (cps.last_of_run !== want.last)) begin
          mismatches++;
          $display("%0t: expected cp %h err %b last %b, got cp %h err %b last %b", $time,
                   want.cp, want.err, want.last, cps.code_point, cps.is_error,
                   cps.last_of_run);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i;
    cycles            = 0;
    mismatches        = 0;
    send_idle_pct     = 37;
    recv_idle_pct     = 46;
    rst_ni            = 1'b0;
    byt.valid         = 1'b0;
    byt.in_byte       = '0;
    byt.end_of_stream = 1'b0;
    cps.ready         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < DirectedN; i++) begin
      send_byte(script[i].b, script[i].eos, script[i].typed, script[i].cp, script[i].err);
    end
    send_random(70);
    send_idle_pct = 46;
    recv_idle_pct = 37;
    send_random(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(90);
    @(negedge clk_i);
    byt.valid <= 1'b0;
    while (cps_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
